// File: rtl/bgmm_pkg.sv
// bgmm_pkg: shared types and constants for the boost group maximum margin tracker
// holds the action codes, the sequencer state type and the fixed field widths
// no dependencies
package bgmm_pkg;

  // fixed widths of the item fields
  localparam int ACTION_W    = 3;
  localparam int CPU_FIELD_W = 3;
  localparam int GRP_FIELD_W = 4;
  localparam int MARGIN_W    = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // largest margin a group may take
  localparam logic [MARGIN_W-1:0] MARGIN_LIMIT = 7'd100;

  // action codes carried in the input tuser
  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 3'd0,
    ACT_DEQUEUE = 3'd1,
    ACT_SET     = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/boost_group_max_margin_tracker_core.sv
// boost_group_max_margin_tracker_core: per cpu maximum margin over active boost groups
// one shared compare unit scans the groups under a small sequencer
// depends on bgmm_pkg
//
//  channel | ports                          | dir | item
//  --------+--------------------------------+-----+------------------------------------
//  in      | in_tvalid in_tready in_tdata   | in  | action, cpu, group, margin
//          | in_tuser                       |     |
//  out     | out_tvalid out_tready out_tdata| out | result cpu, max margin, error
//          | out_tlast                      |     | tlast marks the final result
//
// enqueue and dequeue update the count (not for a group out of range), then scan
// the groups; read and rejected items go straight to the result; set margin and clear
// group scan each cpu in turn; the single margin comparator takes one group per cycle.
// the input is not ready while an item is in work; a result may wait in the output
// register while the next item is accepted, and a stalled output holds the scan.
// synchronous active-low reset clears all margins, activity bits and cpu maxima at once.
module boost_group_max_margin_tracker_core #(
  parameter int NUM_CPUS    = 8,
  parameter int NUM_GROUPS  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] cpu_index, [6:3] group_index, [13:7] margin_value, [15:14] zero
  input  logic [bgmm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] action
  input  logic [bgmm_pkg::ACTION_W-1:0]      in_tuser,
  // result item
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] result_cpu, [9:3] peak_margin, [10] error_flag, [15:11] zero
  output logic [bgmm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);

  localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int GRP_W     = $clog2(NUM_GROUPS);
  localparam int ADDR_W    = CPU_W + GRP_W;
  localparam int CNT_DEPTH = NUM_CPUS << GRP_W;
  localparam int MW        = bgmm_pkg::MARGIN_W;

  // input field split
  logic [bgmm_pkg::CPU_FIELD_W-1:0] in_cpu;
  logic [bgmm_pkg::GRP_FIELD_W-1:0] in_grp;
  logic [MW-1:0]                    in_mval;
  logic [6:0]                       in_cpu_ext;
  logic [6:0]                       in_grp_ext;
  logic [CPU_W-1:0]                 in_cpu_sel;
  logic [GRP_W-1:0]                 in_grp_sel;

  assign in_cpu     = in_tdata[2:0];
  assign in_grp     = in_tdata[6:3];
  assign in_mval    = in_tdata[13:7];
  assign in_cpu_ext = 7'(in_cpu);
  assign in_grp_ext = 7'(in_grp);
  assign in_cpu_sel = in_cpu_ext[CPU_W-1:0];
  assign in_grp_sel = in_grp_ext[GRP_W-1:0];

  // state
  bgmm_pkg::state_t state_r, state_nxt;
  logic [MW-1:0]          margin_r [NUM_GROUPS];
  logic [NUM_GROUPS-1:0]  active_r [NUM_CPUS];
  logic [MW-1:0]          cpu_max_r [NUM_CPUS];
  logic [COUNT_WIDTH-1:0] cnt_mem [CNT_DEPTH];
  logic [COUNT_WIDTH-1:0] cnt_q_r;

  // working registers
  logic [CPU_W-1:0] cpu_r, cpu_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic [GRP_W-1:0] scan_g_r, scan_g_nxt;
  logic [MW-1:0]    best_r, best_nxt;
  logic             enq_r, enq_nxt;
  logic             all_r, all_nxt;
  logic             err_r, err_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [bgmm_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                             out_last_r, out_last_nxt;

  // decode of the offered item
  logic in_acc;
  logic cpu_ok, grp_ok, mval_ok;
  logic dec_err, dec_cnt, dec_scan, dec_set, dec_clr, dec_read;

  assign in_tready = (state_r == bgmm_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cpu_ok    = (32'(in_cpu) < NUM_CPUS);
  assign grp_ok    = (32'(in_grp) < NUM_GROUPS);
  assign mval_ok   = (in_mval <= bgmm_pkg::MARGIN_LIMIT);

  always_comb begin
    dec_err  = 1'b0;
    dec_cnt  = 1'b0;
    dec_scan = 1'b0;
    dec_set  = 1'b0;
    dec_clr  = 1'b0;
    dec_read = 1'b0;
    case (in_tuser)
      bgmm_pkg::ACT_ENQUEUE, bgmm_pkg::ACT_DEQUEUE: begin
        if (!cpu_ok) dec_err = 1'b1;
        else if (grp_ok) dec_cnt = 1'b1;
        else dec_scan = 1'b1;
      end
      bgmm_pkg::ACT_SET: begin
        if (!grp_ok || !mval_ok) dec_err = 1'b1;
        else dec_set = 1'b1;
      end
      bgmm_pkg::ACT_CLEAR: begin
        if (!grp_ok || (in_grp == '0)) dec_err = 1'b1;
        else dec_clr = 1'b1;
      end
      bgmm_pkg::ACT_READ: begin
        if (!cpu_ok) dec_err = 1'b1;
        else dec_read = 1'b1;
      end
      default: dec_err = 1'b1;
    endcase
  end

  // shared compare unit: one group per cycle against the running maximum
  logic          scan_act;
  logic [MW-1:0] scan_margin;
  logic [MW-1:0] best_step;
  logic          scan_last;
  logic          cpu_last;
  logic          slot_free;

  assign scan_margin = margin_r[scan_g_r];
  assign scan_act    = (scan_g_r == '0) || active_r[cpu_r][scan_g_r];
  assign best_step   = (scan_act && (scan_margin > best_r)) ? scan_margin : best_r;
  assign scan_last   = (scan_g_r == GRP_W'(NUM_GROUPS - 1));
  assign cpu_last    = (cpu_r == CPU_W'(NUM_CPUS - 1));
  assign slot_free   = !out_valid_r || out_tready;

  // count update for enqueue and dequeue
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [ADDR_W-1:0]      in_addr;
  logic [ADDR_W-1:0]      cur_addr;

  assign in_addr  = {in_cpu_sel, in_grp_sel};
  assign cur_addr = {cpu_r, grp_r};
  assign cnt_cur  = active_r[cpu_r][grp_r] ? cnt_q_r : '0;

  always_comb begin
    if (enq_r) cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
    else       cnt_new = (cnt_cur == '0) ? cnt_cur : cnt_cur - 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bgmm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (dec_cnt) state_nxt = bgmm_pkg::ST_COUNT;
          else if (dec_scan || dec_set || dec_clr) state_nxt = bgmm_pkg::ST_SCAN;
          else state_nxt = bgmm_pkg::ST_EMIT;
        end
      end
      bgmm_pkg::ST_COUNT: state_nxt = bgmm_pkg::ST_SCAN;
      bgmm_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = bgmm_pkg::ST_EMIT;
      end
      bgmm_pkg::ST_EMIT: begin
        if (slot_free) begin
          if (all_r && !cpu_last) state_nxt = bgmm_pkg::ST_SCAN;
          else state_nxt = bgmm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bgmm_pkg::ST_IDLE;
    endcase
  end

  // datapath and output controls
  logic [6:0] cpu_out_ext;
  assign cpu_out_ext = 7'(cpu_r);

  always_comb begin
    cpu_nxt       = cpu_r;
    grp_nxt       = grp_r;
    scan_g_nxt    = scan_g_r;
    best_nxt      = best_r;
    enq_nxt       = enq_r;
    all_nxt       = all_r;
    err_nxt       = err_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      bgmm_pkg::ST_IDLE: begin
        if (in_acc) begin
          cpu_nxt    = (dec_err || dec_set || dec_clr) ? '0 : in_cpu_sel;
          grp_nxt    = in_grp_sel;
          scan_g_nxt = '0;
          best_nxt   = dec_read ? cpu_max_r[in_cpu_sel] : '0;
          enq_nxt    = (in_tuser == bgmm_pkg::ACT_ENQUEUE);
          all_nxt    = dec_set || dec_clr;
          err_nxt    = dec_err;
        end
      end
      bgmm_pkg::ST_SCAN: begin
        best_nxt   = best_step;
        scan_g_nxt = scan_g_r + 1'b1;
      end
      bgmm_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, err_r, best_r, cpu_out_ext[2:0]};
          out_last_nxt  = !all_r || cpu_last;
          if (all_r && !cpu_last) begin
            cpu_nxt    = cpu_r + 1'b1;
            scan_g_nxt = '0;
            best_nxt   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers and tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bgmm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) margin_r[g] <= '0;
      for (int c = 0; c < NUM_CPUS; c++) begin
        active_r[c]  <= '0;
        cpu_max_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // margin writes on set and clear
      if (in_acc && dec_set) margin_r[in_grp_sel] <= in_mval;
      if (in_acc && dec_clr) begin
        margin_r[in_grp_sel] <= '0;
        for (int c = 0; c < NUM_CPUS; c++) active_r[c][in_grp_sel] <= 1'b0;
      end
      // activity follows the updated count
      if (state_r == bgmm_pkg::ST_COUNT) active_r[cpu_r][grp_r] <= (cnt_new != '0);
      // store the finished maximum
      if ((state_r == bgmm_pkg::ST_SCAN) && scan_last) cpu_max_r[cpu_r] <= best_step;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cpu_r      <= cpu_nxt;
    grp_r      <= grp_nxt;
    scan_g_r   <= scan_g_nxt;
    best_r     <= best_nxt;
    enq_r      <= enq_nxt;
    all_r      <= all_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // task count memory, entries behind a clear activity bit read as zero
  always_ff @(posedge clk) begin
    if (in_acc && dec_cnt) cnt_q_r <= cnt_mem[in_addr];
    if (state_r == bgmm_pkg::ST_COUNT) cnt_mem[cur_addr] <= cnt_new;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // a rejected item reports cpu 0 with zero margin as a single result
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10]) |-> (out_tdata[9:0] == '0) && out_tlast)
    else $error("error result carries data or is not last");

  // reported maxima never exceed the margin limit
  a_max_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[9:3] <= bgmm_pkg::MARGIN_LIMIT))
    else $error("reported margin above limit");

  // the group scan never steps past the last group
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bgmm_pkg::ST_SCAN) |-> (32'(scan_g_r) < NUM_GROUPS))
    else $error("group scan out of range");

  // a scan always ends in the result stage
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == bgmm_pkg::ST_SCAN) && scan_last) |=> (state_r == bgmm_pkg::ST_EMIT))
    else $error("scan did not end in result stage");
`endif

endmodule
